// ===== design/deq_pkg.sv =====
// shared types and codes for the double-ended queue
package deq_pkg;

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_PEEK       = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [2:0]         opcode_t;
    typedef logic signed [31:0] word_t;
    typedef logic [6:0]         count_out_t;
    typedef logic [1:0]         status_t;

endpackage

// ===== design/deq_if.sv =====
// valid/ready channel interfaces for operations and results
interface deq_in_if;
    logic                valid;
    logic                ready;
    deq_pkg::opcode_t    opcode;
    deq_pkg::word_t      push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_out_if;
    logic                  valid;
    logic                  ready;
    deq_pkg::word_t        popped_value;
    deq_pkg::word_t        front_value;
    deq_pkg::word_t        rear_value;
    deq_pkg::count_out_t   item_count;
    deq_pkg::status_t      status;

    modport source (output valid, output popped_value, output front_value,
                    output rear_value, output item_count, output status, input ready);
    modport sink   (input valid, input popped_value, input front_value,
                    input rear_value, input item_count, input status, output ready);
endinterface

// ===== design/double_ended_queue.sv =====
// double-ended queue of signed 32-bit words on a ring buffer in ram
//
// Double-ended queue of DEPTH signed 32-bit words. Each cmd transaction is one
// operation (push front, push rear, pop front, pop rear, or peek for any other
// opcode) and yields exactly one rsp transaction with the popped word (zero if
// none), the front and rear words after the operation (zero when empty), the
// word count and a status (ok, empty error on pop, full error on push; an error
// leaves the queue unchanged). The words live in one ram with a registered read;
// the front and rear words are also held in registers, so pushes, peeks, errors
// and a pop that empties the queue load their result from the idle state. A pop
// that leaves words behind goes through the read state: the new front (or rear)
// word is fetched through the single ram read port. A new cmd transaction is taken
// while a finished result still waits in the output register if that result
// is being taken in the same cycle. The ram needs no clearing after reset:
// only entries that hold stored words are ever read.
module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    cmd,
    deq_out_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int CE = (CW > 7) ? CW : 7;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // wrap a sum below twice the depth into the ring
    function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[AW-1:0];
    endfunction

    // control state
    logic          state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_front_reg, pend_front_next;

    // cached end words and pending pop word
    deq_pkg::word_t front_val_reg, front_val_next;
    deq_pkg::word_t rear_val_reg, rear_val_next;
    deq_pkg::word_t pend_pop_reg, pend_pop_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    deq_pkg::word_t       out_pop_reg, out_pop_next;
    deq_pkg::word_t       out_front_reg, out_front_next;
    deq_pkg::word_t       out_rear_reg, out_rear_next;
    deq_pkg::count_out_t  out_count_reg, out_count_next;
    deq_pkg::status_t     out_status_reg, out_status_next;

    // ram port
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [31:0]    rd_data;

    logic           accept;
    logic           out_load;
    logic           is_empty;
    logic           is_full;
    logic [AW-1:0]  front_dec;
    logic [SW-1:0]  front_ext;
    logic [SW-1:0]  count_ext;
    logic [CE-1:0]  count_wide;
    deq_pkg::word_t load_pop;
    deq_pkg::status_t load_status;

    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_ext = SW'(front_reg);
    assign count_ext = SW'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        pend_front_next = pend_front_reg;
        front_val_next  = front_val_reg;
        rear_val_next   = rear_val_reg;
        pend_pop_next   = pend_pop_reg;
        wr_en           = 1'b0;
        wr_addr         = front_dec;
        rd_en           = 1'b0;
        rd_addr         = wrap_idx(front_ext + SW'(1));
        out_load        = 1'b0;
        load_pop        = '0;
        load_status     = deq_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    case (cmd.opcode)
                        deq_pkg::OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                load_status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = front_dec;
                                front_next     = front_dec;
                                count_next     = count_reg + CW'(1);
                                front_val_next = cmd.push_value;
                                if (is_empty)
                                begin
                                    rear_val_next = cmd.push_value;
                                end
                            end
                        end
                        deq_pkg::OP_PUSH_REAR:
                        begin
                            if (is_full)
                            begin
                                load_status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = wrap_idx(front_ext + count_ext);
                                count_next    = count_reg + CW'(1);
                                rear_val_next = cmd.push_value;
                                if (is_empty)
                                begin
                                    front_val_next = cmd.push_value;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                load_status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                load_pop   = front_val_reg;
                                front_next = wrap_idx(front_ext + SW'(1));
                                count_next = count_reg - CW'(1);
                                // words remain: fetch the new front word
                                if (count_reg > CW'(1))
                                begin
                                    rd_en           = 1'b1;
                                    rd_addr         = wrap_idx(front_ext + SW'(1));
                                    pend_front_next = 1'b1;
                                    pend_pop_next   = front_val_reg;
                                    state_next      = S_READ;
                                    out_load        = 1'b0;
                                end
                            end
                        end
                        deq_pkg::OP_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                load_status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                load_pop   = rear_val_reg;
                                count_next = count_reg - CW'(1);
                                // words remain: fetch the new rear word
                                if (count_reg > CW'(1))
                                begin
                                    rd_en           = 1'b1;
                                    rd_addr         = wrap_idx(front_ext + count_ext - SW'(2));
                                    pend_front_next = 1'b0;
                                    pend_pop_next   = rear_val_reg;
                                    state_next      = S_READ;
                                    out_load        = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            // peek and unused opcodes only report
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // ram data for the new end word is valid now
                if (pend_front_reg)
                begin
                    front_val_next = rd_data;
                end
                else
                begin
                    rear_val_next = rd_data;
                end
                load_pop   = pend_pop_reg;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_wide = CE'(count_next);

    // result register: loaded when a transaction finishes, cleared when taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_pop_next    = out_pop_reg;
        out_front_next  = out_front_reg;
        out_rear_next   = out_rear_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_pop_next    = load_pop;
            out_status_next = load_status;
            out_count_next  = count_wide[6:0];
            out_front_next  = (count_next != '0) ? front_val_next : '0;
            out_rear_next   = (count_next != '0) ? rear_val_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        front_val_reg  <= front_val_next;
        rear_val_reg   <= rear_val_next;
        pend_pop_reg   <= pend_pop_next;
        out_pop_reg    <= out_pop_next;
        out_front_reg  <= out_front_next;
        out_rear_reg   <= out_rear_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_pop_reg;
    assign rsp.front_value  = out_front_reg;
    assign rsp.rear_value   = out_rear_reg;
    assign rsp.item_count   = out_count_reg;
    assign rsp.status       = out_status_reg;

endmodule

// ===== design/deq_ram.sv =====
// generic single-write single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
